[rtl/nfwp_pkg.sv]
// ----------------------------------------------------------------------------
// nfwp_pkg
// Types and constants shared by the node filter and its sequential divider.
// ----------------------------------------------------------------------------
package nfwp_pkg;

    localparam int DIV_W     = 32;
    localparam int HALF_W    = 16;
    localparam int DIV_CNT_W = 6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEP_FLOOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_PROPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WL_ACTIVE    = 2'd2;

    localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;
    localparam logic [31:0] AVG_NUM    = 32'd10000;
    localparam logic [31:0] CAP_MIN    = 32'd100;
    localparam logic [31:0] CAP_ADD    = 32'd100;
    // above this capacity the default average is zero
    localparam logic [31:0] CAP_LIMIT  = AVG_NUM - CAP_ADD;
    localparam logic [31:0] RESP_MIN   = 32'd4;

    localparam int SUM_W = 24;
    localparam int CNT_W = 9;
    localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;
    localparam int CNT_HARD_MAX = 511;

    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic start;
        logic half_op;   // dividend in low 16 bits, 16 iterations
    } nfwp_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nfwp_div_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FILTER = 5'b00010,
        ST_DIV1   = 5'b00100,
        ST_DIV2   = 5'b01000,
        ST_FINISH = 5'b10000
    } nfwp_state_t;

endpackage

[rtl/nfwp_div.sv]
// ----------------------------------------------------------------------------
// nfwp_div
// Restoring unsigned divider, one quotient bit per cycle, 32 or 16 steps.
// ----------------------------------------------------------------------------
module nfwp_div
    import nfwp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  nfwp_div_req_t     req,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    output nfwp_div_sts_t     sts,
    output logic [DIV_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       diff;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = divisor;
            if (req.half_op)
            begin
                quo_next   = {dividend[HALF_W-1:0], {(DIV_W-HALF_W){1'b0}}};
                count_next = DIV_CNT_W'(HALF_W);
            end
            else
            begin
                quo_next   = dividend;
                count_next = DIV_CNT_W'(DIV_W);
            end
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/node_filter_weight_prefix.sv]
// ----------------------------------------------------------------------------
// node_filter_weight_prefix
// Node filter with speed weight and running prefix sum over kept nodes.
// ----------------------------------------------------------------------------
// usage:
//   s_* stream carries one node record per word, s_tlast marks the last node
//   of a list. m_* stream returns one result word per node, m_tlast copies
//   the input's last flag and marks the final totals.
//   cfg_* writes the deposit floor (0), filter_props (1), whitelist_active (2);
//   other indexes are dropped. write only while no node is in flight.
//   a node is processed alone: s_tready is high only in the idle state.
//   a rejected node goes from the filter state to the finish state. a kept node
//   goes through the shared divider twice: avg (32 steps from the response
//   figures, 16 from capacity) and then 65535/avg (16 steps); the second pass
//   is skipped when avg is zero, and the divider sets the rate.
//   the next node is taken the cycle after the result is registered, so a
//   stalled receiver holds at most one finished word while a new node runs;
//   a second finished word waits in the sequencer until the first is taken.
//   reset clears the registers, the running sums and the output valid.
// ----------------------------------------------------------------------------
module node_filter_weight_prefix
    import nfwp_pkg::*;
#(
    parameter int MAX_NODES = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // now time, ban end, deposit, property bits, capacity,
    // response number, response sum
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // boot_node, whitelisted
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // selected, node_weight, range_start, sum including this node, found_count,
    // div_zero, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]           cfg_data
);

    localparam int CntCap = (MAX_NODES < CNT_HARD_MAX) ? MAX_NODES : CNT_HARD_MAX;

    nfwp_state_t state_reg, state_next;

    logic [63:0] dep_floor_reg;
    logic [63:0] filter_props_reg;
    logic        wl_active_reg;

    logic [63:0] now_reg, bl_until_reg, deposit_reg, props_reg;
    logic [31:0] capacity_reg, resp_cnt_reg, resp_tot_reg;
    logic        boot_reg, wl_reg, last_reg;

    logic        sel_reg, sel_next;
    logic        dz_reg, dz_next;
    logic [15:0] weight_reg, weight_next;

    logic [SUM_W-1:0] weight_sum_reg, weight_sum_next;
    logic [CNT_W-1:0] found_total_reg, found_total_next;

    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_valid_reg, out_valid_next;

    nfwp_div_req_t    div_req;
    nfwp_div_sts_t    div_sts;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quotient;

    logic             in_take;
    logic             load_out;
    logic             props_ok;
    logic             pass;
    logic [DIV_W-1:0] cap_divisor;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0] cnt_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dep_floor_reg    <= '0;
            filter_props_reg <= '0;
            wl_active_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEP_FLOOR:    dep_floor_reg    <= cfg_data;
                CFG_FILTER_PROPS: filter_props_reg <= cfg_data;
                CFG_WL_ACTIVE:    wl_active_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg      <= s_tdata[63:0];
            bl_until_reg <= s_tdata[127:64];
            deposit_reg  <= s_tdata[191:128];
            props_reg    <= s_tdata[255:192];
            capacity_reg <= s_tdata[287:256];
            resp_cnt_reg <= s_tdata[319:288];
            resp_tot_reg <= s_tdata[351:320];
            boot_reg     <= s_tuser[0];
            wl_reg       <= s_tuser[1];
            last_reg     <= s_tlast;
        end
    end

    // property filter: required bits present, height at most the configured one unless that is zero
    assign props_ok = ((filter_props_reg[31:0] & props_reg[31:0]) == filter_props_reg[31:0])
                   && ((filter_props_reg[39:32] == 8'd0)
                       || (props_reg[39:32] <= filter_props_reg[39:32]));

    assign pass = (bl_until_reg <= now_reg)
               && (boot_reg
                   || (!(wl_active_reg && !wl_reg)
                       && (deposit_reg >= dep_floor_reg)
                       && props_ok));

    // all ones gives a zero quotient when capacity+100 exceeds 10000
    assign cap_divisor = (capacity_reg > CAP_LIMIT) ? {DIV_W{1'b1}}
                       : ((capacity_reg < CAP_MIN) ? (CAP_MIN + CAP_ADD)
                                                   : (capacity_reg + CAP_ADD));

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        dz_next      = dz_reg;
        weight_next  = weight_reg;
        div_req      = '0;
        div_dividend = resp_tot_reg;
        div_divisor  = resp_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER:
            begin
                sel_next    = pass;
                dz_next     = 1'b0;
                weight_next = '0;
                if (!pass)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    if (resp_cnt_reg <= RESP_MIN)
                    begin
                        div_req.half_op = 1'b1;
                        div_dividend    = AVG_NUM;
                        div_divisor     = cap_divisor;
                    end
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_sts.done)
                begin
                    if (div_quotient == '0)
                    begin
                        dz_next     = 1'b1;
                        weight_next = WEIGHT_MAX;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        div_req.start   = 1'b1;
                        div_req.half_op = 1'b1;
                        div_dividend    = {{(DIV_W-HALF_W){1'b0}}, WEIGHT_MAX};
                        div_divisor     = div_quotient;
                        state_next      = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_sts.done)
                begin
                    weight_next = div_quotient[HALF_W-1:0];
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    nfwp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    // running sums with saturation
    assign sum_add = {1'b0, weight_sum_reg} + (SUM_W+1)'(weight_reg);
    assign sum_new = sel_reg ? (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0])
                             : weight_sum_reg;
    assign cnt_new = (sel_reg && (found_total_reg < CNT_W'(CntCap)))
                   ? found_total_reg + 1'b1 : found_total_reg;

    always_comb
    begin
        weight_sum_next  = weight_sum_reg;
        found_total_next = found_total_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_last_next  = last_reg;
            out_data_next  = {5'd0, dz_reg, cnt_new, sum_new, weight_sum_reg,
                              weight_reg, sel_reg};
            // the last node closes the list
            weight_sum_next  = last_reg ? '0 : sum_new;
            found_total_next = last_reg ? '0 : cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            weight_sum_reg  <= '0;
            found_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            weight_sum_reg  <= weight_sum_next;
            found_total_reg <= found_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        dz_reg       <= dz_next;
        weight_reg   <= weight_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    // divider is never busy while a new word can be accepted
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !div_sts.busy)
        else $error("divider busy in idle state");

    // a rejected node carries no weight and leaves the sum unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |->
            (m_tdata[16:1] == 16'd0) && (m_tdata[64:41] == m_tdata[40:17])
            && !m_tdata[74])
        else $error("rejected node with weight");

    // the running sums restart after the last node
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_reg) |=> (weight_sum_reg == '0) && (found_total_reg == '0))
        else $error("sums not cleared after last node");

    assert property (@(posedge clk) disable iff (!rst_n)
        found_total_reg <= CNT_W'(CntCap))
        else $error("node count above cap");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for node_filter_weight_prefix. Node records are queued
// by the stimulus process and streamed in by a clocked driver; a clocked
// monitor compares every result word against an in-bench model of the
// filter, the speed weight and the running prefix sums. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import nfwp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP    = 256;
    localparam int COUNT_CAP   = (LIST_CAP < CNT_HARD_MAX) ? LIST_CAP : CNT_HARD_MAX;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [63:0] now_time;
        logic [63:0] ban_end;
        logic [63:0] deposit;
        logic [63:0] prop_bits;
        logic [31:0] capacity;
        logic [31:0] resp_num;
        logic [31:0] resp_sum;
        logic        boot_node;
        logic        whitelisted;
        logic        final_rec;
    } node_t;

    typedef struct packed {
        logic        selected;
        logic [15:0] node_weight;
        logic [23:0] range_start;
        logic [23:0] sum_incl;
        logic [8:0]  found_count;
        logic        div_zero;
        logic        last_out;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [63:0]           cfg_data = '0;

    // register shadow and running sums of the model
    logic [63:0] min_dep_shadow = '0;
    logic [63:0] props_shadow = '0;
    logic        wl_shadow = 1'b0;
    logic [23:0] weight_acc = '0;
    logic [8:0]  found_acc = '0;

    node_t    pend_nodes[$];
    outcome_t outcome_q[$];
    node_t    cur_node;

    int pushed_cnt = 0;
    int got_cnt = 0;
    int err_cnt = 0;
    int kept_cnt = 0;
    int lists_closed = 0;
    int clamp_cnt = 0;
    int reg_writes = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int rdy_gap = 0;
    int send_gap = 0;
    bit no_idle = 1'b0;

    node_filter_weight_prefix #(.MAX_NODES(LIST_CAP)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (err_cnt < 40)
            $display("mismatch %s at word %0d: got %0h, expected %0h", what, got_cnt,
                     got, want);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] spread64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] spread32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return '1;
            2: return 32'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    // filter decision, speed weight and prefix sums for one node record
    function automatic outcome_t node_outcome(input node_t n);
        outcome_t    o;
        logic        keep;
        logic [63:0] avg;
        logic [32:0] base;
        logic [24:0] sum;
        keep = 1'b1;
        o = '0;
        if (n.ban_end > n.now_time)
            keep = 1'b0;
        else if (!n.boot_node)
        begin
            if (wl_shadow && !n.whitelisted)
                keep = 1'b0;
            else if (n.deposit < min_dep_shadow)
                keep = 1'b0;
            else if ((props_shadow[31:0] & n.prop_bits[31:0]) != props_shadow[31:0])
                keep = 1'b0;
            else if (props_shadow[39:32] != 8'd0 && n.prop_bits[39:32] > props_shadow[39:32])
                keep = 1'b0;
        end
        o.range_start = weight_acc;
        if (keep)
        begin
            if (n.resp_num > RESP_MIN)
                avg = 64'(n.resp_sum / n.resp_num);
            else
            begin
                base = 33'((n.capacity < CAP_MIN) ? CAP_MIN : n.capacity) + 33'(CAP_ADD);
                avg = 64'(AVG_NUM) / 64'(base);
            end
            if (avg == 64'd0)
            begin
                o.node_weight = WEIGHT_MAX;
                o.div_zero = 1'b1;
            end
            else
                o.node_weight = 16'(64'(WEIGHT_MAX) / avg);
            sum = 25'(weight_acc) + 25'(o.node_weight);
            if (sum > 25'(SUM_MAX))
            begin
                weight_acc = SUM_MAX;
                clamp_cnt++;
            end
            else
                weight_acc = sum[23:0];
            if (found_acc < 9'(COUNT_CAP))
                found_acc = found_acc + 9'd1;
            kept_cnt++;
        end
        o.selected = keep;
        o.sum_incl = weight_acc;
        o.found_count = found_acc;
        o.last_out = n.final_rec;
        if (n.final_rec)
        begin
            weight_acc = '0;
            found_acc = '0;
            lists_closed++;
        end
        return o;
    endfunction

    // node record driver
    always @(posedge clk)
    begin
        node_t nx;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(node_outcome(cur_node));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pend_nodes.size() > 0)
                begin
                    nx = pend_nodes.pop_front();
                    cur_node <= nx;
                    s_tdata <= {nx.resp_sum, nx.resp_num, nx.capacity,
                                nx.prop_bits, nx.deposit, nx.ban_end,
                                nx.now_time};
                    s_tuser <= {nx.whitelisted, nx.boot_node};
                    s_tlast <= nx.final_rec;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with long holds on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_done < hold_requests)
        begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (rdy_gap > 0)
        begin
            rdy_gap <= rdy_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0)
                rdy_gap <= pick_gap();
        end
    end

    // register shadow follows accepted writes; unused index is dropped
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_writes++;
            case (cfg_index)
                CFG_DEP_FLOOR:    min_dep_shadow <= cfg_data;
                CFG_FILTER_PROPS: props_shadow <= cfg_data;
                CFG_WL_ACTIVE:    wl_shadow <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcome_q.size() == 0)
                flag_mismatch("unexpected word", 64'(m_tdata), 64'd0);
            else
            begin
                want = outcome_q.pop_front();
                if (m_tdata[0] !== want.selected)
                    flag_mismatch("selected", 64'(m_tdata[0]), 64'(want.selected));
                if (m_tdata[16:1] !== want.node_weight)
                    flag_mismatch("node_weight", 64'(m_tdata[16:1]), 64'(want.node_weight));
                if (m_tdata[40:17] !== want.range_start)
                    flag_mismatch("range_start", 64'(m_tdata[40:17]), 64'(want.range_start));
                if (m_tdata[64:41] !== want.sum_incl)
                    flag_mismatch("sum_incl", 64'(m_tdata[64:41]),
                                  64'(want.sum_incl));
                if (m_tdata[73:65] !== want.found_count)
                    flag_mismatch("found_count", 64'(m_tdata[73:65]), 64'(want.found_count));
                if (m_tdata[74] !== want.div_zero)
                    flag_mismatch("div_zero", 64'(m_tdata[74]), 64'(want.div_zero));
                if (m_tdata[79:75] !== 5'd0)
                    flag_mismatch("zero fill", 64'(m_tdata[79:75]), 64'd0);
                if (m_tlast !== want.last_out)
                    flag_mismatch("last_out", 64'(m_tlast), 64'(want.last_out));
            end
            got_cnt++;
        end
    end

    task automatic queue_node(input node_t n);
        pend_nodes.push_back(n);
        pushed_cnt++;
    endtask

    task automatic wait_idle();
        while (got_cnt < pushed_cnt)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // keepable record under the directed register setting
    function automatic node_t plain_node();
        node_t n;
        n.now_time = 64'd5000;
        n.ban_end = 64'd0;
        n.boot_node = 1'b0;
        n.whitelisted = 1'b1;
        n.deposit = 64'd1000;
        n.prop_bits = 64'h0000_0005_0000_00F0;
        n.capacity = 32'd0;
        n.resp_num = 32'd10;
        n.resp_sum = 32'd1000;
        n.final_rec = 1'b0;
        return n;
    endfunction

    function automatic node_t random_node(input bit well_formed);
        node_t       n;
        logic [63:0] d;
        logic [7:0]  hc;
        n.now_time = spread64();
        n.boot_node = ($urandom_range(0, 4) == 0);
        n.final_rec = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: n.capacity = 32'($urandom_range(0, 200));
            1: n.capacity = 32'($urandom_range(9800, 10000));
            default: n.capacity = spread32();
        endcase
        case ($urandom_range(0, 3))
            0: n.resp_num = 32'($urandom_range(0, 4));
            1: n.resp_num = 32'($urandom_range(5, 100));
            default: n.resp_num = spread32();
        endcase
        if ($urandom_range(0, 2) == 0)
            n.resp_sum = n.resp_num * 32'($urandom_range(0, 300));
        else
            n.resp_sum = spread32();
        if (well_formed)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    d = spread64();
                    n.ban_end = (n.now_time > d) ? n.now_time - d : 64'd0;
                end
                4, 5: n.ban_end = n.now_time;
                6, 7: n.ban_end = 64'd0;
                default: n.ban_end = {$urandom, $urandom};
            endcase
            n.whitelisted = ($urandom_range(0, 9) != 0);
            n.deposit = min_dep_shadow | spread64();
            n.prop_bits = {$urandom, $urandom} | {32'd0, props_shadow[31:0]};
            hc = props_shadow[39:32];
            if (hc != 8'd0)
                n.prop_bits[39:32] = 8'($urandom_range(0, int'(hc)));
        end
        else
        begin
            n.ban_end = spread64();
            n.whitelisted = 1'($urandom_range(0, 1));
            n.deposit = spread64();
            n.prop_bits = spread64();
        end
        return n;
    endfunction

    initial
    begin
        node_t n;
        int    ph;
        int    k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: filters one by one, then the weight corners
        write_reg(CFG_DEP_FLOOR, 64'd1000);
        write_reg(CFG_FILTER_PROPS, 64'h0000_000A_0000_00F0);
        write_reg(CFG_WL_ACTIVE, 64'd1);
        wait_idle();
        n = plain_node();
        queue_node(n);
        n.ban_end = n.now_time;
        queue_node(n);
        n.ban_end = n.now_time + 64'd1;
        queue_node(n);
        n.boot_node = 1'b1;
        queue_node(n);
        n = plain_node();
        n.whitelisted = 1'b0;
        queue_node(n);
        n.boot_node = 1'b1;
        n.deposit = 64'd0;
        n.prop_bits = 64'd0;
        queue_node(n);
        n = plain_node();
        n.deposit = 64'd999;
        queue_node(n);
        n = plain_node();
        n.prop_bits[31:0] = 32'h0000_0070;
        queue_node(n);
        n = plain_node();
        n.prop_bits[39:32] = 8'h0B;
        queue_node(n);
        n.prop_bits[39:32] = 8'h0A;
        queue_node(n);
        n.prop_bits[39:32] = 8'h00;
        queue_node(n);
        n = plain_node();
        n.resp_num = 32'd4;
        queue_node(n);
        n.resp_num = 32'd5;
        n.resp_sum = 32'd0;
        queue_node(n);
        n.resp_sum = 32'd25;
        queue_node(n);
        n.resp_num = 32'd0;
        n.capacity = 32'd9900;
        queue_node(n);
        n.capacity = 32'd9901;
        queue_node(n);
        n.capacity = '1;
        queue_node(n);
        n.resp_num = '1;
        n.resp_sum = '1;
        queue_node(n);
        n.resp_num = 32'd5;
        queue_node(n);
        n.resp_num = 32'd4;
        n.capacity = 32'd150;
        n.final_rec = 1'b1;
        queue_node(n);
        wait_idle();

        // register extremes; the unused index must change nothing
        write_reg(CFG_DEP_FLOOR, '1);
        write_reg(CFG_FILTER_PROPS, '1);
        write_reg(CFG_UNUSED_IDX, 64'd0);
        wait_idle();
        n = plain_node();
        n.deposit = '1;
        n.prop_bits = '1;
        queue_node(n);
        n.deposit = 64'hFFFF_FFFF_FFFF_FFFE;
        queue_node(n);
        n.now_time = '1;
        n.ban_end = '1;
        n.boot_node = 1'b1;
        n.final_rec = 1'b1;
        queue_node(n);
        wait_idle();

        // long list of saturating boot nodes drives sum and count into their caps
        write_reg(CFG_DEP_FLOOR, 64'd0);
        write_reg(CFG_FILTER_PROPS, 64'd0);
        write_reg(CFG_WL_ACTIVE, 64'hFFFF_FFFF_FFFF_FFFE);
        wait_idle();
        for (k = 0; k < 300; k++)
        begin
            n = random_node(1'b0);
            n.ban_end = 64'd0;
            n.boot_node = 1'b1;
            n.capacity = '1;
            n.resp_num = 32'($urandom_range(0, 4));
            n.final_rec = (k == 299);
            queue_node(n);
        end
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 3 == 0)
                write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
            if (ph == 0)
            begin
                write_reg(CFG_DEP_FLOOR, 64'd0);
                write_reg(CFG_FILTER_PROPS, 64'd0);
                write_reg(CFG_WL_ACTIVE, 64'd0);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_DEP_FLOOR, '1);
                write_reg(CFG_FILTER_PROPS, '1);
                write_reg(CFG_WL_ACTIVE, '1);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_DEP_FLOOR, 64'd0);
                    1: write_reg(CFG_DEP_FLOOR, 64'($urandom_range(0, 1000)));
                    default: write_reg(CFG_DEP_FLOOR, {$urandom, $urandom});
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_FILTER_PROPS, 64'd0);
                    1: write_reg(CFG_FILTER_PROPS, {$urandom, $urandom});
                    default: write_reg(CFG_FILTER_PROPS,
                                       {$urandom, $urandom & $urandom & $urandom});
                endcase
                write_reg(CFG_WL_ACTIVE, {$urandom, $urandom});
            end
            wait_idle();
            no_idle = (ph == 2 || ph == 7);
            // receiver stalls long while records keep coming
            if (ph == 4)
                hold_requests++;
            for (k = 0; k < PHASE_ITEMS; k++)
                queue_node(random_node($urandom_range(0, 9) < 8));
            wait_idle();
            no_idle = 1'b0;
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (outcome_q.size() != 0)
            flag_mismatch("results never delivered", 64'(outcome_q.size()), 64'd0);
        $display("covered %0d node records, %0d kept, %0d lists closed, %0d register writes",
                 pushed_cnt, kept_cnt, lists_closed, reg_writes);
        $display("weight sum hit its cap %0d times, %0d result words checked",
                 clamp_cnt, got_cnt);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/nfwp_pkg.sv
rtl/nfwp_div.sv
rtl/node_filter_weight_prefix.sv
verif/testbench.sv
